[rtl/core/ptb_pkg.sv]
// Package for the palindromic tree builder: sizes, node record and sequencer states.
`default_nettype none
package ptb_pkg;
   localparam int MAX_LEN   = 4096;
   localparam int SYM_BITS  = 8;
   localparam int TEXT_AW   = $clog2(MAX_LEN);
   localparam int NODE_AW   = $clog2(MAX_LEN + 2);
   localparam int NODES     = MAX_LEN + 2;
   localparam int CNT_W     = TEXT_AW + 1;

   localparam logic [NODE_AW-1:0] ODD_ROOT  = NODE_AW'(0);
   localparam logic [NODE_AW-1:0] EVEN_ROOT = NODE_AW'(1);
   localparam logic [NODE_AW-1:0] NO_CHILD  = NODE_AW'(0);

   typedef struct packed {
      logic [CNT_W-1:0]    len;
      logic [NODE_AW-1:0]  link;
      logic [TEXT_AW-1:0]  fstart;
      logic [CNT_W-1:0]    ecnt;
      logic [SYM_BITS-1:0] esym;
      logic [NODE_AW-1:0]  enext;
   } node_rec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_W_NODE,
      ST_W_TXT,
      ST_W_CMP,
      ST_F_HEAD,
      ST_F_HWAIT,
      ST_F_NODE,
      ST_F_CHK,
      ST_MK_NODE,
      ST_MK_HEAD,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

[rtl/core/palindromic_tree_builder.sv]
// Palindromic tree (eertree) builder: sequencer over text, node and child-head memories.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------------
//  input   | req_character, req_new_string          | start && !busy
//  result  | rsp_node_id .. rsp_overflow            | rsp_valid, one cycle, no stall
//
// One item takes a data-dependent time after accept: a suffix-link step reads the node,
// then the text, then compares; a non-root child-list head adds a wait (root heads are
// registers); each child entry is a node read, then a symbol compare; the list end is
// seen in ST_F_NODE; a new node takes the second walk for its link, then node and head
// writes, then the strobe; an overflowed item strobes in the cycle after accept.
// Reset is synchronous and leaves an empty string; no clearing pass is needed,
// since child lists are headed from registers for the roots and each new
// node's head is written when it is created. The receiver cannot stall.
`default_nettype none
module palindromic_tree_builder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [7:0]                   req_character,
   input  wire logic                         req_new_string,
   output logic                              rsp_valid,
   output logic [12:0]                       rsp_node_id,
   output logic [12:0]                       rsp_pal_length,
   output logic [11:0]                       rsp_pal_start,
   output logic                              rsp_is_new,
   output logic [12:0]                       rsp_end_count,
   output logic [12:0]                       rsp_distinct_count,
   output logic                              rsp_overflow
);
   localparam int NAW = ptb_pkg::NODE_AW;
   localparam int TAW = ptb_pkg::TEXT_AW;
   localparam int CW  = ptb_pkg::CNT_W;
   localparam int SB  = ptb_pkg::SYM_BITS;

   // memories
   logic [SB-1:0]             text_mem [ptb_pkg::MAX_LEN];
   ptb_pkg::node_rec_type     node_mem [ptb_pkg::NODES];
   logic [NAW-1:0]            head_mem [ptb_pkg::NODES];

   logic [SB-1:0]             text_rd_ff;
   ptb_pkg::node_rec_type     node_rd_ff;
   logic [NAW-1:0]            head_rd_ff;

   // write controls
   logic                      text_we;
   logic [TAW-1:0]            text_wa, text_ra;
   logic [SB-1:0]             text_wd;
   logic                      node_we;
   logic [NAW-1:0]            node_wa;
   ptb_pkg::node_rec_type     node_wd;
   logic                      head_we;
   logic [NAW-1:0]            head_wa, head_wd;

   ptb_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic [CW-1:0]             total_ff, total_in;
   logic [NAW-1:0]            last_ff, last_in;
   logic [NAW-1:0]            head0_ff, head0_in, head1_ff, head1_in;
   logic [SB-1:0]             sym_ff, sym_in;
   logic [NAW-1:0]            k_ff, k_in;        // node under test
   logic [NAW-1:0]            p_ff, p_in;        // parent of the new suffix
   logic [CW-1:0]             lenv_ff, lenv_in;  // length of p plus two
   logic [NAW-1:0]            linkp_ff, linkp_in;
   logic [NAW-1:0]            headp_ff, headp_in;
   logic [NAW-1:0]            link_ff, link_in;  // link of the new node
   logic                      walk2_ff, walk2_in;
   logic [CW:0]               klen_ff, klen_in;  // signed length of k
   logic [NAW-1:0]            klink_ff, klink_in;
   logic                      hit_ff, hit_in, miss_ff, miss_in;

   logic [12:0]               o_node_ff, o_node_in, o_len_ff, o_len_in;
   logic [11:0]               o_start_ff, o_start_in;
   logic                      o_new_ff, o_new_in, o_ovf_ff, o_ovf_in;
   logic [12:0]               o_ecnt_ff, o_ecnt_in, o_dist_ff, o_dist_in;

   // walk helpers
   logic [CW:0]               cur_len;
   logic [NAW-1:0]            cur_link;
   logic [CW+1:0]             left;
   logic                      sym_match;
   logic [CW-1:0]             epos;
   logic [NAW-1:0]            new_v;
   logic [NAW-1:0]            head_sel;

   always_ff @(posedge clock) begin
      if (text_we) text_mem[text_wa] <= text_wd;
      text_rd_ff <= text_mem[text_ra];
      if (node_we) node_mem[node_wa] <= node_wd;
      node_rd_ff <= node_mem[k_ff];
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[k_ff];
   end

   always_comb begin
      unique case (k_ff)
         ptb_pkg::ODD_ROOT: begin
            cur_len  = '1;
            cur_link = ptb_pkg::ODD_ROOT;
         end
         ptb_pkg::EVEN_ROOT: begin
            cur_len  = '0;
            cur_link = ptb_pkg::ODD_ROOT;
         end
         default: begin
            cur_len  = {1'b0, node_rd_ff.len};
            cur_link = node_rd_ff.link;
         end
      endcase
      left      = {2'b00, pos_ff} - {cur_len[CW], cur_len} - (CW+2)'(1);
      sym_match = (text_rd_ff == sym_ff);
      epos      = req_new_string ? '0 : pos_ff;
      new_v     = NAW'(total_ff) + NAW'(1);
      unique case (k_ff)
         ptb_pkg::ODD_ROOT:  head_sel = head0_ff;
         ptb_pkg::EVEN_ROOT: head_sel = head1_ff;
         default:            head_sel = head_rd_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptb_pkg::ST_IDLE:
            if (start) state_in = (epos >= CW'(ptb_pkg::MAX_LEN)) ? ptb_pkg::ST_DONE
                                                                 : ptb_pkg::ST_W_NODE;
         ptb_pkg::ST_W_NODE:  state_in = ptb_pkg::ST_W_TXT;
         ptb_pkg::ST_W_TXT:   state_in = ptb_pkg::ST_W_CMP;
         ptb_pkg::ST_W_CMP:
            state_in = (hit_ff || (!miss_ff && sym_match)) ? ptb_pkg::ST_F_HEAD
                                                           : ptb_pkg::ST_W_NODE;
         ptb_pkg::ST_F_HEAD:
            state_in = (k_ff == ptb_pkg::ODD_ROOT || k_ff == ptb_pkg::EVEN_ROOT)
                       ? ptb_pkg::ST_F_NODE : ptb_pkg::ST_F_HWAIT;
         ptb_pkg::ST_F_HWAIT: state_in = ptb_pkg::ST_F_NODE;
         ptb_pkg::ST_F_NODE:
            if (k_ff != ptb_pkg::NO_CHILD)    state_in = ptb_pkg::ST_F_CHK;
            else if (walk2_ff || p_ff == ptb_pkg::ODD_ROOT) state_in = ptb_pkg::ST_MK_NODE;
            else                              state_in = ptb_pkg::ST_W_NODE;
         ptb_pkg::ST_F_CHK:
            if (node_rd_ff.esym != sym_ff)    state_in = ptb_pkg::ST_F_NODE;
            else if (walk2_ff)                state_in = ptb_pkg::ST_MK_NODE;
            else                              state_in = ptb_pkg::ST_DONE;
         ptb_pkg::ST_MK_NODE: state_in = ptb_pkg::ST_MK_HEAD;
         ptb_pkg::ST_MK_HEAD: state_in = ptb_pkg::ST_DONE;
         ptb_pkg::ST_DONE:    state_in = ptb_pkg::ST_IDLE;
         default:             state_in = ptb_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      pos_in = pos_ff;   total_in = total_ff;  last_in = last_ff;
      head0_in = head0_ff; head1_in = head1_ff; sym_in = sym_ff;
      k_in = k_ff; p_in = p_ff; lenv_in = lenv_ff; linkp_in = linkp_ff;
      headp_in = headp_ff; link_in = link_ff; walk2_in = walk2_ff;
      klen_in = klen_ff; klink_in = klink_ff; hit_in = hit_ff; miss_in = miss_ff;
      o_node_in = o_node_ff; o_len_in = o_len_ff; o_start_in = o_start_ff;
      o_new_in = o_new_ff; o_ecnt_in = o_ecnt_ff; o_dist_in = o_dist_ff;
      o_ovf_in = o_ovf_ff;
      text_we = 1'b0; text_wa = epos[TAW-1:0]; text_wd = req_character[SB-1:0];
      text_ra = left[TAW-1:0];
      node_we = 1'b0; node_wa = k_ff; node_wd = node_rd_ff;
      head_we = 1'b0; head_wa = p_ff; head_wd = new_v;

      unique case (state_ff)
         ptb_pkg::ST_IDLE:
            if (start) begin
               if (req_new_string) begin
                  pos_in = '0; total_in = '0; last_in = ptb_pkg::ODD_ROOT;
                  head0_in = ptb_pkg::NO_CHILD; head1_in = ptb_pkg::NO_CHILD;
               end
               sym_in = req_character[SB-1:0];
               k_in = req_new_string ? ptb_pkg::ODD_ROOT : last_ff;
               walk2_in = 1'b0;
               if (epos >= CW'(ptb_pkg::MAX_LEN)) begin
                  // string full: report only the distinct count
                  o_node_in = '0; o_len_in = '0; o_start_in = '0; o_new_in = 1'b0;
                  o_ecnt_in = '0; o_ovf_in = 1'b1;
                  o_dist_in = 13'(req_new_string ? '0 : total_ff);
               end else begin
                  text_we = 1'b1;
               end
            end
         ptb_pkg::ST_W_TXT: begin
            klen_in  = cur_len;
            klink_in = cur_link;
            hit_in   = (k_ff == ptb_pkg::ODD_ROOT);
            miss_in  = left[CW+1];
         end
         ptb_pkg::ST_W_CMP:
            if (hit_ff || (!miss_ff && sym_match)) begin
               if (!walk2_ff) begin
                  p_in     = k_ff;
                  lenv_in  = CW'(klen_ff + (CW+1)'(2));
                  linkp_in = klink_ff;
               end
            end else begin
               k_in = klink_ff;
            end
         ptb_pkg::ST_F_HEAD:
            if (k_ff == ptb_pkg::ODD_ROOT || k_ff == ptb_pkg::EVEN_ROOT) begin
               k_in = head_sel;
               if (!walk2_ff) headp_in = head_sel;
            end
         ptb_pkg::ST_F_HWAIT: begin
            k_in = head_sel;
            if (!walk2_ff) headp_in = head_sel;
         end
         ptb_pkg::ST_F_NODE:
            if (k_ff == ptb_pkg::NO_CHILD) begin
               link_in = ptb_pkg::EVEN_ROOT;
               if (!walk2_ff) begin
                  total_in = total_ff + CW'(1);
                  if (p_ff != ptb_pkg::ODD_ROOT) begin
                     k_in = linkp_ff;
                     walk2_in = 1'b1;
                  end
               end
            end
         ptb_pkg::ST_F_CHK:
            if (node_rd_ff.esym != sym_ff) begin
               k_in = node_rd_ff.enext;
            end else if (walk2_ff) begin
               link_in = k_ff;
            end else begin
               // existing node: bump its end count
               node_we = 1'b1;
               node_wd.ecnt = node_rd_ff.ecnt + CW'(1);
               o_node_in = 13'(k_ff - NAW'(1));
               o_len_in = 13'(node_rd_ff.len);
               o_start_in = node_rd_ff.fstart;
               o_new_in = 1'b0;
               o_ecnt_in = 13'(node_rd_ff.ecnt + CW'(1));
               o_dist_in = 13'(total_ff);
               o_ovf_in = 1'b0;
               last_in = k_ff;
               pos_in = pos_ff + CW'(1);
            end
         ptb_pkg::ST_MK_NODE: begin
            node_we = 1'b1;
            node_wa = new_v;
            node_wd.len = lenv_ff;
            node_wd.link = link_ff;
            node_wd.fstart = TAW'(pos_ff - lenv_ff + CW'(1));
            node_wd.ecnt = CW'(1);
            node_wd.esym = sym_ff;
            node_wd.enext = headp_ff;
            if (p_ff == ptb_pkg::ODD_ROOT)       head0_in = new_v;
            else if (p_ff == ptb_pkg::EVEN_ROOT) head1_in = new_v;
            else                                 head_we = 1'b1;
            o_node_in = 13'(total_ff);
            o_len_in = 13'(lenv_ff);
            o_start_in = TAW'(pos_ff - lenv_ff + CW'(1));
            o_new_in = 1'b1;
            o_ecnt_in = 13'(1);
            o_dist_in = 13'(total_ff);
            o_ovf_in = 1'b0;
            last_in = new_v;
            pos_in = pos_ff + CW'(1);
         end
         ptb_pkg::ST_MK_HEAD: begin
            head_we = 1'b1;
            head_wa = last_ff;
            head_wd = ptb_pkg::NO_CHILD;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      busy               = (state_ff != ptb_pkg::ST_IDLE);
      rsp_valid          = (state_ff == ptb_pkg::ST_DONE);
      rsp_node_id        = o_node_ff;
      rsp_pal_length     = o_len_ff;
      rsp_pal_start      = o_start_ff;
      rsp_is_new         = o_new_ff;
      rsp_end_count      = o_ecnt_ff;
      rsp_distinct_count = o_dist_ff;
      rsp_overflow       = o_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::ST_IDLE;
         pos_ff   <= '0;
         total_ff <= '0;
         last_ff  <= ptb_pkg::ODD_ROOT;
         head0_ff <= ptb_pkg::NO_CHILD;
         head1_ff <= ptb_pkg::NO_CHILD;
         walk2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         last_ff  <= last_in;
         head0_ff <= head0_in;
         head1_ff <= head1_in;
         walk2_ff <= walk2_in;
      end
      sym_ff <= sym_in;   k_ff <= k_in;   p_ff <= p_in;
      lenv_ff <= lenv_in; linkp_ff <= linkp_in; headp_ff <= headp_in;
      link_ff <= link_in; klen_ff <= klen_in; klink_ff <= klink_in;
      hit_ff <= hit_in;   miss_ff <= miss_in;
      o_node_ff <= o_node_in; o_len_ff <= o_len_in; o_start_ff <= o_start_in;
      o_new_ff <= o_new_in;   o_ecnt_ff <= o_ecnt_in; o_dist_ff <= o_dist_in;
      o_ovf_ff <= o_ovf_in;
   end
endmodule
`default_nettype wire

[sim/tb_palindromic_tree_builder.sv]
// Self-checking testbench for the palindromic tree builder: eertree predictor and item checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_palindromic_tree_builder;

   // one result as the block reports it
   typedef struct {
      logic [12:0] node_id;
      logic [12:0] pal_length;
      logic [11:0] pal_start;
      logic        is_new;
      logic [12:0] end_count;
      logic [12:0] distinct_count;
      logic        overflow;
   } pal_result_type;

   // Scoreboard: keeps its own copy of the tree and the queue of expected results.
   class palin_scoreboard;
      int unsigned    text_sym [ptb_pkg::MAX_LEN];
      int             node_len [ptb_pkg::NODES];
      int unsigned    node_link [ptb_pkg::NODES];
      int unsigned    node_first [ptb_pkg::NODES];
      int unsigned    node_hits [ptb_pkg::NODES];
      int unsigned    child_of [int unsigned];   // key: node * 2^SYM_BITS + symbol
      int unsigned    str_pos, node_count, longest_node;
      pal_result_type pending [$];
      int             errors, results_seen, nodes_made, overflows, max_len_seen;

      function new();
         errors = 0; results_seen = 0; nodes_made = 0; overflows = 0; max_len_seen = 0;
         clear_tree();
      endfunction

      function void clear_tree();
         node_len[ptb_pkg::ODD_ROOT] = -1;  node_link[ptb_pkg::ODD_ROOT] = ptb_pkg::ODD_ROOT;
         node_len[ptb_pkg::EVEN_ROOT] = 0;  node_link[ptb_pkg::EVEN_ROOT] = ptb_pkg::ODD_ROOT;
         child_of.delete();
         str_pos = 0; node_count = 0; longest_node = ptb_pkg::ODD_ROOT;
      endfunction

      // palindrome of node k ending at p can be wrapped by sym
      function bit wraps(int p, int unsigned k, int unsigned sym);
         int left;
         left = p - node_len[k] - 1;
         if (left < 0 || left >= p + 1) return 0;
         return text_sym[left] == sym;
      endfunction

      // accepted item: advance the tree and queue what the block must answer
      function void note_item(logic [7:0] ch, logic fresh);
         pal_result_type exp_res;
         int unsigned    sym, par, nd, u, sfx;
         int             p;
         sym = ch;
         if (fresh) clear_tree();
         exp_res = '{default: '0};
         if (str_pos >= ptb_pkg::MAX_LEN) begin
            // string full: nothing changes
            exp_res.distinct_count = node_count[12:0];
            exp_res.overflow = 1'b1;
            pending.insert(pending.size(), exp_res);
            return;
         end
         p = str_pos;
         text_sym[p] = sym;
         par = longest_node;
         while (!wraps(p, par, sym)) par = node_link[par];
         if (child_of.exists(par * 256 + sym)) begin
            nd = child_of[par * 256 + sym];
         end else begin
            node_count++;
            nd = node_count + 1;
            exp_res.is_new = 1'b1;
            nodes_made++;
            node_len[nd] = node_len[par] + 2;
            node_first[nd] = p - node_len[nd] + 1;
            node_hits[nd] = 0;
            if (par == ptb_pkg::ODD_ROOT) begin
               sfx = ptb_pkg::EVEN_ROOT;   // single symbol hangs off the odd root
            end else begin
               u = node_link[par];
               while (!wraps(p, u, sym)) u = node_link[u];
               sfx = child_of.exists(u * 256 + sym) ? child_of[u * 256 + sym]
                                                     : ptb_pkg::EVEN_ROOT;
            end
            node_link[nd] = sfx;
            child_of[par * 256 + sym] = nd;
         end
         longest_node = nd;
         node_hits[nd]++;
         str_pos++;
         if (node_len[nd] > max_len_seen) max_len_seen = node_len[nd];
         exp_res.node_id        = 13'(nd - 1);
         exp_res.pal_length     = 13'(node_len[nd]);
         exp_res.pal_start      = 12'(node_first[nd]);
         exp_res.end_count      = 13'(node_hits[nd]);
         exp_res.distinct_count = 13'(node_count);
         pending.insert(pending.size(), exp_res);
      endfunction

      function void check_result(pal_result_type got);
         pal_result_type want;
         results_seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, node_id %0d", $time, got.node_id);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.overflow) overflows++;
         if (got.node_id !== want.node_id) begin
            $display("%0t: node_id exp %0d got %0d", $time, want.node_id, got.node_id);
            errors++;
         end
         if (got.pal_length !== want.pal_length) begin
            $display("%0t: pal_length exp %0d got %0d", $time, want.pal_length, got.pal_length);
            errors++;
         end
         if (got.pal_start !== want.pal_start) begin
            $display("%0t: pal_start exp %0d got %0d", $time, want.pal_start, got.pal_start);
            errors++;
         end
         if (got.is_new !== want.is_new) begin
            $display("%0t: is_new exp %0d got %0d", $time, want.is_new, got.is_new);
            errors++;
         end
         if (got.end_count !== want.end_count) begin
            $display("%0t: end_count exp %0d got %0d", $time, want.end_count, got.end_count);
            errors++;
         end
         if (got.distinct_count !== want.distinct_count) begin
            $display("%0t: distinct_count exp %0d got %0d", $time,
                     want.distinct_count, got.distinct_count);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow exp %0d got %0d", $time, want.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock, reset, start;
   logic        busy;
   logic [7:0]  req_character;
   logic        req_new_string;
   logic        rsp_valid;
   logic [12:0] rsp_node_id, rsp_pal_length, rsp_end_count, rsp_distinct_count;
   logic [11:0] rsp_pal_start;
   logic        rsp_is_new, rsp_overflow;

   palin_scoreboard tree_sb = new();
   int              cycles = 0;
   int              items_sent = 0;
   bit              no_gaps = 0;      // set for the back-to-back stretch

   palindromic_tree_builder uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_character(req_character), .req_new_string(req_new_string),
      .rsp_valid(rsp_valid), .rsp_node_id(rsp_node_id), .rsp_pal_length(rsp_pal_length),
      .rsp_pal_start(rsp_pal_start), .rsp_is_new(rsp_is_new), .rsp_end_count(rsp_end_count),
      .rsp_distinct_count(rsp_distinct_count), .rsp_overflow(rsp_overflow)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  tree_sb.pending.size());
         $display("tb_palindromic_tree_builder: done, errors");
         $finish;
      end
   end

   // result monitor: block cannot be stalled, every strobe is one item
   always @(posedge clock) begin
      pal_result_type got;
      if (!reset && rsp_valid) begin
         got.node_id = rsp_node_id;         got.pal_length = rsp_pal_length;
         got.pal_start = rsp_pal_start;     got.is_new = rsp_is_new;
         got.end_count = rsp_end_count;     got.distinct_count = rsp_distinct_count;
         got.overflow = rsp_overflow;
         tree_sb.check_result(got);
      end
   end

   // Drive one item: optional idle gap, then hold start until the block takes it.
   // start stays high on return so back-to-back items never toggle it.
   task automatic send_item(input logic [7:0] ch, input logic fresh);
      int gap;
      gap = no_gaps ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_character <= ch;
      req_new_string <= fresh;
      do @(posedge clock); while (busy);
      tree_sb.note_item(ch, fresh);
      items_sent++;
   endtask

   // One random string: alphabet of random size at a random base, sometimes mirrored.
   task automatic send_random_string();
      int          alpha, len, base, k;
      bit          mirror;
      logic [7:0]  half [$];
      case ($urandom_range(0, 4)) inside
         0:       alpha = 1;
         1, 2:    alpha = 2;
         3:       alpha = 3;
         default: alpha = 256;
      endcase
      base   = $urandom_range(0, 256 - alpha);
      len    = $urandom_range(1, 40);
      mirror = $urandom_range(0, 2) == 0;
      for (k = 0; k < len; k++)
         half.insert(half.size(), 8'(base + $urandom_range(0, alpha - 1)));
      if (mirror)
         for (k = len - 1 - $urandom_range(0, 1); k >= 0; k--)
            half.insert(half.size(), half[k]);
      foreach (half[k]) begin
         // occasional restart mid-string as noise
         send_item(half[k], k == 0 || $urandom_range(0, 60) == 0);
      end
   endtask

   initial begin
      logic [7:0] dir_chars [6] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
      logic [7:0] aba [10] = '{"a", "b", "a", "c", "a", "b", "a", "a", "b", "a"};
      int         k;
      start = 1'b0;
      req_character = '0;
      req_new_string = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme symbols without a restart right after reset
      foreach (dir_chars[k]) send_item(dir_chars[k], 1'b0);
      // restart, then nested palindromes and repeated suffixes
      foreach (aba[k]) send_item(aba[k], k == 0);
      // restart with a single symbol, twice in a row
      send_item(8'h7E, 1'b1);
      send_item(8'h81, 1'b1);
      send_item(8'h81, 1'b0);

      // random strings
      while (items_sent < 440) send_random_string();

      // one-symbol run: long suffix-link chains and the longest palindromes,
      // first half back to back
      no_gaps = 1;
      send_item(8'h5A, 1'b1);
      for (k = 1; k < 64; k++) begin
         if (k == 32) no_gaps = 0;
         send_item(8'h5A, 1'b0);
      end
      // a restart after the long run
      send_item(8'hA5, 1'b1);
      send_item(8'h5A, 1'b0);
      send_item(8'hA5, 1'b0);
      start <= 1'b0;

      while (tree_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d items, %0d results, %0d new nodes, %0d overflowed items",
               items_sent, tree_sb.results_seen, tree_sb.nodes_made, tree_sb.overflows);
      $display("longest palindrome %0d, cycles %0d", tree_sb.max_len_seen, cycles);
      if (tree_sb.errors == 0)
         $display("tb_palindromic_tree_builder: done, clean");
      else
         $display("tb_palindromic_tree_builder: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/core/ptb_pkg.sv
rtl/core/palindromic_tree_builder.sv
sim/tb_palindromic_tree_builder.sv
